// File: src/ppm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame generator package
// Shared widths, register indexes, request codes and reset constants.
// ----------------------------------------------------------------------------
package ppm_pkg;

    // Field widths
    localparam int WIDTH_W = 12;   // stored pulse width
    localparam int PERIOD_W = 16;  // timer period and frame length
    localparam int SLOT_W = 4;     // slot code on the result side
    localparam int CHAN_W = 3;     // channel index of a write request
    localparam int LEVEL_W = 10;   // channel level of a write request
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 2'd2;

    // Request kinds carried in tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Reset values
    localparam logic [PERIOD_W-1:0] FRAME_RESET = 16'd22500;
    localparam logic [WIDTH_W-1:0] PMIN_RESET = 12'd900;
    localparam logic [WIDTH_W-1:0] PMAX_RESET = 12'd2300;
    localparam logic [WIDTH_W-1:0] PULSE_MID = 12'd1600;

    // Full-scale level, divisor of the scaling
    localparam logic [LEVEL_W-1:0] LEVEL_TOP = 10'd1023;

    // Table write from the scaler to the pulse memory
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  addr;
        logic [WIDTH_W-1:0] data;
    } tbl_wr_t;

endpackage

// File: src/ppm_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM level scaler
// Two-stage pipeline: width = pulse_min + level*(pulse_max-pulse_min)/1023,
// truncated toward zero. Stage one multiplies the magnitudes, stage two
// divides by 1023 through a reciprocal series and one correction step.
// ----------------------------------------------------------------------------
module ppm_scale
    import ppm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [CHAN_W-1:0]  chan,
    input  logic [LEVEL_W-1:0] level,
    input  logic [WIDTH_W-1:0] pulse_min,
    input  logic [WIDTH_W-1:0] pulse_max,
    output tbl_wr_t            wr
);

    localparam int PROD_W = LEVEL_W + WIDTH_W;  // 22 bits

    logic [WIDTH_W:0]    diff;
    logic                neg;
    logic [WIDTH_W-1:0]  mag;
    logic [PROD_W-1:0]   prod_next;

    logic                valid_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic                neg_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic [PROD_W:0]     series;
    logic [12:0]         q_est;
    logic [PROD_W:0]     q_times;
    logic [PROD_W:0]     rem;
    logic [12:0]         quot;

    // Sign and magnitude of the span, so the quotient truncates toward zero
    always_comb
    begin
        diff = {1'b0, pulse_max} - {1'b0, pulse_min};
        neg = diff[WIDTH_W];
        mag = neg ? WIDTH_W'(-diff) : diff[WIDTH_W-1:0];
        prod_next = {{WIDTH_W{1'b0}}, level} * {{LEVEL_W{1'b0}}, mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            chan_reg <= chan;
            neg_reg <= neg;
            prod_reg <= prod_next;
        end
    end

    // 1/1023 = (1/1024)(1 + 2^-10 + 2^-20 + ...); estimate is low by at most one
    always_comb
    begin
        series = {1'b0, prod_reg} + {11'd0, prod_reg[PROD_W-1:10]}
                 + {21'd0, prod_reg[PROD_W-1:20]};
        q_est = series[PROD_W:10];
        q_times = {q_est, 10'd0} - {10'd0, q_est};
        rem = {1'b0, prod_reg} - q_times;
        quot = (rem >= {13'd0, LEVEL_TOP}) ? q_est + 13'd1 : q_est;
        wr.en = valid_reg;
        wr.addr = SLOT_W'(chan_reg);
        wr.data = neg_reg ? pulse_min - quot[WIDTH_W-1:0]
                          : pulse_min + quot[WIDTH_W-1:0];
    end

endmodule

// File: src/ppm_frame_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame generator
// Scales channel levels into pulse widths held in a small memory and plays
// them out, one timer period per tick, followed by the clamped sync gap.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Transaction
// s_axis    in   write request (tuser = 0) or timer tick (tuser = 1)
// m_axis    out  one timer period per tick; write requests give nothing
// cfg       in   register write, no handshake, taken when cfg_we is high
//
// One request per cycle is sustained while the output is not stalled. A
// tick reads the pulse memory at acceptance; its period then passes the tick
// stage and the output register. A write request is registered in the
// multiplier stage and written into the memory in the following cycle; a
// tick reading that entry in that cycle takes the new width via a bypass register.
// Reset clears the slot pointer, the running sum, the entry valid bits and
// all handshake state; an entry never written reads as the reset midpoint.
// A stall on m_axis holds the output register and the tick stage, and
// s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
module ppm_frame_generator
    import ppm_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // chan_index[2:0], chan_value[12:3]
    input  logic                  s_axis_tuser,   // req_type[0]

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // period_ticks[15:0]
    output logic [4:0]            m_axis_tuser    // slot[3:0], sync_underflow[4]
);

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PTR_W = $clog2(NUM_CHANNELS + 1);

    // Configuration registers
    logic [PERIOD_W-1:0] frame_len_reg;
    logic [WIDTH_W-1:0]  pmin_reg;
    logic [WIDTH_W-1:0]  pmax_reg;

    // Input unpacking
    logic                s_accept;
    logic                in_req;
    logic [CHAN_W-1:0]   in_chan;
    logic [LEVEL_W-1:0]  in_level;
    logic                wr_req;
    logic                tick_req;

    // Scaler write into the table
    tbl_wr_t             wr;
    logic [CH_AW-1:0]    wr_addr;

    // Pulse memory and entry valid bits
    logic [WIDTH_W-1:0]  pulse_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] vld_reg;

    // Slot sequencing
    logic [PTR_W-1:0]    ptr_reg;
    logic [PTR_W-1:0]    ptr_next;
    logic                ptr_is_chan;
    logic [CH_AW-1:0]    rd_addr;
    logic                rd_en;

    // Tick stage: memory data plus bypass
    logic                s1_valid_reg;
    logic                s1_sync_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    logic [WIDTH_W-1:0]  s1_rdata_reg;
    logic                s1_vld_reg;
    logic                s1_byp_reg;
    logic [WIDTH_W-1:0]  s1_bdata_reg;
    logic                s1_adv;
    logic [WIDTH_W-1:0]  s1_width;

    // Running sum and sync gap
    logic [PERIOD_W-1:0] sum_reg;
    logic [PERIOD_W-1:0] sum_next;
    logic                gap_under;
    logic [PERIOD_W-1:0] gap;

    // Output register
    logic                out_valid_reg;
    logic [PERIOD_W-1:0] out_period_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_under_reg;

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes drop
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg <= FRAME_RESET;
            pmin_reg <= PMIN_RESET;
            pmax_reg <= PMAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_LENGTH: frame_len_reg <= cfg_wdata;
                REG_PULSE_MIN:    pmin_reg <= cfg_wdata[WIDTH_W-1:0];
                REG_PULSE_MAX:    pmax_reg <= cfg_wdata[WIDTH_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    assign s1_adv = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    assign in_req = s_axis_tuser;
    assign in_chan = s_axis_tdata[CHAN_W-1:0];
    assign in_level = s_axis_tdata[CHAN_W+LEVEL_W-1:CHAN_W];

    // Drop writes aimed beyond the last channel
    assign wr_req = s_accept && (in_req == REQ_WRITE) && (32'(in_chan) < NUM_CHANNELS);
    assign tick_req = s_accept && (in_req == REQ_TICK);

    ppm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wr_req),
        .chan      (in_chan),
        .level     (in_level),
        .pulse_min (pmin_reg),
        .pulse_max (pmax_reg),
        .wr        (wr)
    );

    assign wr_addr = wr.addr[CH_AW-1:0];

    // ------------------------------------------------------------------
    // Slot pointer: advance through the channels, then the sync slot
    // ------------------------------------------------------------------
    always_comb
    begin
        ptr_is_chan = 32'(ptr_reg) < NUM_CHANNELS;
        ptr_next = ptr_reg;
        if (tick_req)
        begin
            ptr_next = ptr_is_chan ? ptr_reg + PTR_W'(1) : '0;
        end
        rd_addr = ptr_reg[CH_AW-1:0];
        rd_en = tick_req && ptr_is_chan;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    // ------------------------------------------------------------------
    // Pulse memory: one write port from the scaler, one registered read
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            pulse_mem[wr_addr] <= wr.data;
        end
        if (rd_en)
        begin
            s1_rdata_reg <= pulse_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Tick stage: capture slot info, valid bit and same-cycle bypass
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick_req)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_req)
        begin
            s1_sync_reg <= !ptr_is_chan;
            s1_slot_reg <= ptr_is_chan ? SLOT_W'(ptr_reg) : SLOT_W'(NUM_CHANNELS);
            s1_vld_reg <= vld_reg[rd_addr];
            // Write landing at this edge is invisible to the read: bypass it
            s1_byp_reg <= wr.en && (wr_addr == rd_addr);
            s1_bdata_reg <= wr.data;
        end
    end

    always_comb
    begin
        if (s1_byp_reg)
        begin
            s1_width = s1_bdata_reg;
        end
        else if (s1_vld_reg)
        begin
            s1_width = s1_rdata_reg;
        end
        else
        begin
            s1_width = PULSE_MID;
        end
    end

    // ------------------------------------------------------------------
    // Running sum and sync gap, clamped at zero
    // ------------------------------------------------------------------
    always_comb
    begin
        gap_under = sum_reg > frame_len_reg;
        gap = gap_under ? '0 : frame_len_reg - sum_reg;
        sum_next = sum_reg;
        if (s1_adv)
        begin
            sum_next = s1_sync_reg ? '0 : sum_reg + PERIOD_W'(s1_width);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register; hold while the sink stalls
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_period_reg <= s1_sync_reg ? gap : PERIOD_W'(s1_width);
            out_slot_reg <= s1_slot_reg;
            out_under_reg <= s1_sync_reg && gap_under;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_period_reg;
    assign m_axis_tuser = {out_under_reg, out_slot_reg};

endmodule
